// ----- rtl/core/mor_pkg.sv -----
`default_nettype none
package mor_pkg;

   localparam int SampleW = 16;
   localparam int CountW = 5;
   localparam int ThreshW = 16;
   localparam int CsrIdxW = 1;
   localparam int CsrDataW = 16;

   localparam int MaxWindowDefault = 16;

   localparam logic [CountW-1:0] WinLenReset = 5'd16;
   localparam logic [ThreshW-1:0] ThreshReset = 16'd100;
   localparam logic [CountW-1:0] MinTestCount = 5'd3;

   localparam logic [CsrIdxW-1:0] CSR_WINDOW_LENGTH = 1'b0;
   localparam logic [CsrIdxW-1:0] CSR_OUTLIER_THRESHOLD = 1'b1;

   localparam logic ACTION_SAMPLE = 1'b0;
   localparam logic ACTION_CLEAR = 1'b1;

   typedef logic signed [SampleW-1:0] sample_type;
   typedef logic [CountW-1:0] count_type;

endpackage
`default_nettype wire

// ----- rtl/core/median_outlier_reject_filter.sv -----
// Sequence: a clear goes straight to the finish step, a rejected request via the check step;
// an accepted sample takes an insertion sweep over the sorted memory while the window fills,
// and a removal sweep plus an insertion sweep over the sorted memory once it is full.
// Throughput: one request at a time, set by the one-entry-per-cycle sweeps of the sorted memory.
// Reset (synchronous, active high) empties the window, sets the length to 16 and the threshold
// to 100; sample memories are not cleared, only entries below the fill count are ever read.
`default_nettype none
module median_outlier_reject_filter #(
   parameter int MAX_WINDOW = mor_pkg::MaxWindowDefault
) (
   input  wire                              clock,
   input  wire                              reset,
   input  wire                              req_valid,
   output logic                             req_ready,
   input  wire                              req_action,
   input  wire  signed [mor_pkg::SampleW-1:0] req_sample,
   output logic                             rsp_valid,
   input  wire                              rsp_ready,
   output logic                             rsp_accepted,
   output logic signed [mor_pkg::SampleW-1:0] rsp_median_out,
   output logic [mor_pkg::CountW-1:0]       rsp_valid_count,
   output logic                             rsp_ready_res,
   input  wire                              csr_wr_en,
   input  wire  [mor_pkg::CsrIdxW-1:0]      csr_index,
   input  wire  [mor_pkg::CsrDataW-1:0]     csr_wdata
);
   import mor_pkg::*;

   localparam int IW = $clog2(MAX_WINDOW);
   localparam int LenCap = (MAX_WINDOW > 31) ? 31 : MAX_WINDOW;

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_CHK  = 3'd1;
   localparam logic [2:0] S_ACC  = 3'd2;
   localparam logic [2:0] S_REM  = 3'd3;
   localparam logic [2:0] S_INS  = 3'd4;
   localparam logic [2:0] S_LAST = 3'd5;
   localparam logic [2:0] S_MED  = 3'd6;
   localparam logic [2:0] S_FIN  = 3'd7;

   logic [2:0] state_ff, state_in;
   count_type fill_ff, fill_in;
   logic [IW-1:0] wp_ff, wp_in;
   count_type wl_ff, wl_in;
   logic [ThreshW-1:0] thr_ff, thr_in;
   sample_type smp_ff, smp_in;
   sample_type old_ff, old_in;
   count_type iss_ff, iss_in;
   logic iss_go_ff, iss_go_in;
   logic pend_ff, pend_in;
   count_type didx_ff, didx_in;
   logic found_ff, found_in;
   logic acc_ff, acc_in;

   logic rsp_valid_ff, rsp_valid_in;
   logic rsp_acc_ff, rsp_acc_in;
   sample_type rsp_med_ff, rsp_med_in;
   count_type rsp_cnt_ff, rsp_cnt_in;
   logic rsp_rdy_ff, rsp_rdy_in;

   // window in arrival order and the same samples kept sorted ascending
   sample_type circ_mem [MAX_WINDOW];
   sample_type circ_rd_ff;
   logic circ_we;

   sample_type srt_mem [MAX_WINDOW];
   sample_type srt_rd_ff;
   logic srt_we;
   logic [IW-1:0] srt_wa, srt_ra;
   sample_type srt_wd;

   count_type len;
   count_type wp_inc;
   logic [SampleW:0] diff;
   logic [SampleW:0] abs_diff;
   logic reject;
   logic rem_match;
   logic rem_exit;
   logic load_rsp;
   count_type ins_m;

   always_comb begin
      if (wl_ff == '0) begin
         len = CountW'(1);
      end else if (wl_ff > CountW'(LenCap)) begin
         len = CountW'(LenCap);
      end else begin
         len = wl_ff;
      end
   end

   assign wp_inc = CountW'(wp_ff) + CountW'(1);
   assign diff = {smp_ff[SampleW-1], smp_ff} - {srt_rd_ff[SampleW-1], srt_rd_ff};
   assign abs_diff = diff[SampleW] ? (~diff + (SampleW+1)'(1)) : diff;
   assign reject = abs_diff > {1'b0, thr_ff};
   assign rem_match = (srt_rd_ff == old_ff);
   assign rem_exit = (state_ff == S_REM) && pend_ff && (didx_ff == fill_ff - CountW'(1));
   assign load_rsp = (state_ff == S_FIN) && (!rsp_valid_ff || rsp_ready);

   always_comb begin
      state_in = state_ff;
      fill_in = fill_ff;
      wp_in = wp_ff;
      wl_in = wl_ff;
      thr_in = thr_ff;
      smp_in = smp_ff;
      old_in = old_ff;
      iss_in = iss_ff;
      iss_go_in = iss_go_ff;
      pend_in = pend_ff;
      didx_in = didx_ff;
      found_in = found_ff;
      acc_in = acc_ff;
      circ_we = 1'b0;
      srt_we = 1'b0;
      srt_wa = '0;
      srt_wd = smp_ff;
      srt_ra = IW'(fill_ff >> 1);
      ins_m = '0;
      req_ready = (state_ff == S_IDLE);

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               smp_in = req_sample;
               acc_in = 1'b0;
               if (req_action == ACTION_CLEAR) begin
                  fill_in = '0;
                  wp_in = '0;
                  state_in = S_FIN;
               end else if (fill_ff >= MinTestCount) begin
                  state_in = S_CHK;
               end else begin
                  state_in = S_ACC;
               end
            end
         end
         S_CHK: begin
            // sorted read data holds the current median here
            state_in = reject ? S_FIN : S_ACC;
         end
         S_ACC: begin
            circ_we = 1'b1;
            wp_in = (wp_inc == len) ? '0 : IW'(wp_inc);
            old_in = circ_rd_ff;
            acc_in = 1'b1;
            if (fill_ff == len) begin
               iss_in = '0;
               pend_in = 1'b0;
               found_in = 1'b0;
               state_in = S_REM;
            end else begin
               fill_in = fill_ff + CountW'(1);
               ins_m = fill_ff;
               pend_in = 1'b0;
               iss_in = ins_m - CountW'(1);
               iss_go_in = 1'b1;
               state_in = (ins_m == '0) ? S_LAST : S_INS;
            end
         end
         S_REM: begin
            // drop the evicted sample: shift everything above it down one place
            srt_ra = IW'(iss_ff);
            pend_in = (iss_ff < fill_ff);
            didx_in = iss_ff;
            if (iss_ff < fill_ff) begin
               iss_in = iss_ff + CountW'(1);
            end
            if (pend_ff) begin
               if (found_ff) begin
                  srt_we = 1'b1;
                  srt_wa = IW'(didx_ff - CountW'(1));
                  srt_wd = srt_rd_ff;
               end else if (rem_match) begin
                  found_in = 1'b1;
               end
            end
            if (rem_exit) begin
               ins_m = fill_ff - CountW'(1);
               pend_in = 1'b0;
               iss_in = ins_m - CountW'(1);
               iss_go_in = 1'b1;
               state_in = (ins_m == '0) ? S_LAST : S_INS;
            end
         end
         S_INS: begin
            // walk down from the top, moving larger entries up until the slot is found
            srt_ra = IW'(iss_ff);
            pend_in = iss_go_ff;
            didx_in = iss_ff;
            if (iss_go_ff) begin
               if (iss_ff == '0) begin
                  iss_go_in = 1'b0;
               end else begin
                  iss_in = iss_ff - CountW'(1);
               end
            end
            if (pend_ff) begin
               srt_we = 1'b1;
               srt_wa = IW'(didx_ff + CountW'(1));
               if (srt_rd_ff > smp_ff) begin
                  srt_wd = srt_rd_ff;
                  if (didx_ff == '0) begin
                     state_in = S_LAST;
                  end
               end else begin
                  srt_wd = smp_ff;
                  state_in = S_MED;
               end
            end
         end
         S_LAST: begin
            srt_we = 1'b1;
            srt_wa = '0;
            srt_wd = smp_ff;
            state_in = S_MED;
         end
         S_MED: begin
            state_in = S_FIN;
         end
         S_FIN: begin
            if (load_rsp) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      if (csr_wr_en) begin
         case (csr_index)
            CSR_WINDOW_LENGTH: begin
               wl_in = csr_wdata[CountW-1:0];
               fill_in = '0;
               wp_in = '0;
            end
            CSR_OUTLIER_THRESHOLD: begin
               thr_in = csr_wdata[ThreshW-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_acc_in = rsp_acc_ff;
      rsp_med_in = rsp_med_ff;
      rsp_cnt_in = rsp_cnt_ff;
      rsp_rdy_in = rsp_rdy_ff;
      if (load_rsp) begin
         rsp_valid_in = 1'b1;
         rsp_acc_in = acc_ff;
         rsp_med_in = (fill_ff == '0) ? '0 : srt_rd_ff;
         rsp_cnt_in = fill_ff;
         rsp_rdy_in = (fill_ff >= (len >> 1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         fill_ff <= '0;
         wp_ff <= '0;
         wl_ff <= WinLenReset;
         thr_ff <= ThreshReset;
         iss_go_ff <= 1'b0;
         pend_ff <= 1'b0;
         found_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         fill_ff <= fill_in;
         wp_ff <= wp_in;
         wl_ff <= wl_in;
         thr_ff <= thr_in;
         iss_go_ff <= iss_go_in;
         pend_ff <= pend_in;
         found_ff <= found_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      smp_ff <= smp_in;
      old_ff <= old_in;
      iss_ff <= iss_in;
      didx_ff <= didx_in;
      acc_ff <= acc_in;
      rsp_acc_ff <= rsp_acc_in;
      rsp_med_ff <= rsp_med_in;
      rsp_cnt_ff <= rsp_cnt_in;
      rsp_rdy_ff <= rsp_rdy_in;
   end

   always_ff @(posedge clock) begin
      if (circ_we) begin
         circ_mem[wp_ff] <= smp_ff;
      end
      circ_rd_ff <= circ_mem[wp_ff];
   end

   always_ff @(posedge clock) begin
      if (srt_we) begin
         srt_mem[srt_wa] <= srt_wd;
      end
      srt_rd_ff <= srt_mem[srt_ra];
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_accepted = rsp_acc_ff;
   assign rsp_median_out = rsp_med_ff;
   assign rsp_valid_count = rsp_cnt_ff;
   assign rsp_ready_res = rsp_rdy_ff;

   a_fill_in_range: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= len)
      else $error("fill count exceeds active window length");

   a_rsp_from_fin: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == S_FIN))
      else $error("response raised outside the finish step");

   a_evicted_found: assert property (@(posedge clock) disable iff (reset)
      rem_exit |-> (found_ff || rem_match))
      else $error("evicted sample missing from sorted window");

   a_wp_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE) |-> (CountW'(wp_ff) < len))
      else $error("write position beyond active window");

endmodule
`default_nettype wire

// ----- sim/median_filter_checker.sv -----
module median_filter_checker (
   input  wire                              clock,
   input  wire                              reset,
   input  wire                              req_valid,
   input  wire                              req_ready,
   input  wire                              req_action,
   input  wire  signed [mor_pkg::SampleW-1:0] req_sample,
   input  wire                              rsp_valid,
   input  wire                              rsp_ready,
   input  wire                              rsp_accepted,
   input  wire  signed [mor_pkg::SampleW-1:0] rsp_median_out,
   input  wire  [mor_pkg::CountW-1:0]       rsp_valid_count,
   input  wire                              rsp_ready_res,
   input  wire                              csr_wr_en,
   input  wire  [mor_pkg::CsrIdxW-1:0]      csr_index,
   input  wire  [mor_pkg::CsrDataW-1:0]     csr_wdata,
   output int                               mismatch_count,
   output int                               pending_count,
   output int                               checked_count,
   output int                               rejected_count
);
   timeunit 1ns;
   timeprecision 1ps;
   import mor_pkg::*;

   typedef struct packed {
      logic       accepted;
      sample_type median;
      count_type  count;
      logic       ready_res;
   } filter_rsp_type;

   sample_type         win_mem [MaxWindowDefault];
   logic [3:0]         wr_pos;
   count_type          fill;
   logic [CountW-1:0]  len_reg;
   logic [ThreshW-1:0] thr_reg;
   filter_rsp_type     expected_rsp_q [$];

   function automatic int active_len();
      if (len_reg == '0) return 1;
      if (int'(len_reg) > MaxWindowDefault) return MaxWindowDefault;
      return int'(len_reg);
   endfunction

   // upper median of the held entries, zero when empty
   function automatic int window_median();
      int sorted [MaxWindowDefault];
      int n;
      int key;
      int j;
      n = int'(fill);
      if (n == 0) return 0;
      if (n > MaxWindowDefault) n = MaxWindowDefault;
      for (int i = 0; i < n; i++) sorted[i] = int'(win_mem[i]);
      for (int i = 1; i < n; i++) begin
         key = sorted[i];
         j = i;
         while (j > 0 && sorted[j-1] > key) begin
            sorted[j] = sorted[j-1];
            j--;
         end
         sorted[j] = key;
      end
      return sorted[n/2];
   endfunction

   function automatic filter_rsp_type step_filter(input logic act, input sample_type smp);
      filter_rsp_type r;
      int len;
      int d;
      logic take;
      len = active_len();
      take = 1'b0;
      if (int'(fill) > len) fill = count_type'(len);
      if (int'(wr_pos) >= len) wr_pos = '0;
      if (act == ACTION_CLEAR) begin
         fill = '0;
         wr_pos = '0;
      end else begin
         take = 1'b1;
         if (fill >= MinTestCount) begin
            d = int'(smp) - window_median();
            if (d < 0) d = -d;
            if (d > int'(thr_reg)) take = 1'b0;
         end
         if (take) begin
            if (int'(fill) < len) fill = fill + 1'b1;
            win_mem[wr_pos] = smp;
            wr_pos = 4'((int'(wr_pos) + 1) % len);
         end
      end
      r.accepted = take;
      r.median = sample_type'(window_median());
      r.count = fill;
      r.ready_res = (int'(fill) >= len / 2);
      return r;
   endfunction

   initial begin
      mismatch_count = 0;
      pending_count = 0;
      checked_count = 0;
      rejected_count = 0;
   end

   always @(posedge clock) begin
      filter_rsp_type want;
      filter_rsp_type got;
      if (reset) begin
         wr_pos = '0;
         fill = '0;
         len_reg = WinLenReset;
         thr_reg = ThreshReset;
         expected_rsp_q.delete();
      end else begin
         if (csr_wr_en) begin
            if (csr_index == CSR_WINDOW_LENGTH) begin
               len_reg = csr_wdata[CountW-1:0];
               wr_pos = '0;
               fill = '0;
            end else if (csr_index == CSR_OUTLIER_THRESHOLD) begin
               thr_reg = csr_wdata[ThreshW-1:0];
            end
         end
         if (rsp_valid && rsp_ready) begin
            got = '{rsp_accepted, rsp_median_out, rsp_valid_count, rsp_ready_res};
            if (expected_rsp_q.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("%0t: response with no request waiting: acc=%0d med=%0d cnt=%0d rdy=%0d",
                           $realtime, got.accepted, $signed(got.median), got.count,
                           got.ready_res);
            end else begin
               want = expected_rsp_q.pop_front();
               checked_count++;
               if (got.accepted !== want.accepted || got.median !== want.median ||
                   got.count !== want.count || got.ready_res !== want.ready_res) begin
                  mismatch_count++;
                  if (mismatch_count <= 10)
                     $display({"%0t: mismatch: expected acc=%0d med=%0d cnt=%0d rdy=%0d,",
                               " got acc=%0d med=%0d cnt=%0d rdy=%0d"},
                              $realtime, want.accepted, $signed(want.median), want.count,
                              want.ready_res, got.accepted, $signed(got.median), got.count,
                              got.ready_res);
               end
            end
         end
         if (req_valid && req_ready) begin
            want = step_filter(req_action, req_sample);
            if (req_action == ACTION_SAMPLE && !want.accepted) rejected_count++;
            expected_rsp_q.push_back(want);
         end
      end
      pending_count <= expected_rsp_q.size();
   end

endmodule

// ----- sim/tb_top.sv -----
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;
   import mor_pkg::*;

   logic                       clock = 1'b0;
   logic                       reset = 1'b1;
   logic                       req_valid = 1'b0;
   logic                       req_ready;
   logic                       req_action = ACTION_SAMPLE;
   logic signed [SampleW-1:0]  req_sample = '0;
   logic                       rsp_valid;
   logic                       rsp_ready = 1'b0;
   logic                       rsp_accepted;
   logic signed [SampleW-1:0]  rsp_median_out;
   logic [CountW-1:0]          rsp_valid_count;
   logic                       rsp_ready_res;
   logic                       csr_wr_en = 1'b0;
   logic [CsrIdxW-1:0]         csr_index = '0;
   logic [CsrDataW-1:0]        csr_wdata = '0;

   int mismatch_count;
   int pending_count;
   int checked_count;
   int rejected_count;

   int send_idle_pct = 0;
   int recv_stall_pct = 0;
   int sent_count = 0;
   int clear_count = 0;
   int setting_count = 0;
   logic hold_armed = 1'b0;
   logic hold_done = 1'b0;
   int hold_left = 0;

   int len_set [12] = '{16, 1, 2, 3, 5, 8, 0, 31, 4, 15, 16, 7};

   median_filter_checker checker_i (.*);

   median_outlier_reject_filter dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready),
      .req_action(req_action), .req_sample(req_sample),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_accepted(rsp_accepted), .rsp_median_out(rsp_median_out),
      .rsp_valid_count(rsp_valid_count), .rsp_ready_res(rsp_ready_res),
      .csr_wr_en(csr_wr_en), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always #4 clock = ~clock;

   initial begin
      #5ms;
      $display("*** FAILED ***");
      $finish;
   end

   // one long hold-off while the sender keeps offering requests
   always @(posedge clock) begin
      if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_ready <= 1'b0;
      end else if (hold_armed && !hold_done) begin
         hold_left <= 400;
         hold_done <= 1'b1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   task automatic send_req(input logic act, input int smp);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_action <= act;
      req_sample <= smp[SampleW-1:0];
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      sent_count++;
      if (act == ACTION_CLEAR) clear_count++;
   endtask

   task automatic wait_drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_csr(input logic [CsrIdxW-1:0] idx, input logic [CsrDataW-1:0] data);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      @(posedge clock);
      setting_count++;
   endtask

   task automatic run_phase(input int n_items, input int base, input int thr);
      int r;
      int v;
      int spread;
      for (int k = 0; k < n_items; k++) begin
         r = $urandom_range(99);
         if (r < 4) begin
            send_req(ACTION_CLEAR, int'($urandom_range(65535)));
         end else begin
            if (r < 10) begin
               v = int'($urandom_range(65535)) - 32768;
            end else if (r < 13) begin
               v = r[0] ? 32767 : -32768;
            end else begin
               // stay mostly near the phase base value, with some outliers
               spread = thr + thr / 2 + 1;
               if (spread > 40000) spread = 40000;
               v = base + int'($urandom_range(2 * spread)) - spread;
            end
            if (v > 32767) v = 32767;
            if (v < -32768) v = -32768;
            send_req(ACTION_SAMPLE, v);
         end
      end
   endtask

   initial begin
      int thr;
      int len;
      logic [CsrDataW-1:0] len_word;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset settings: length 16, threshold 100
      send_req(ACTION_CLEAR, 16'h1234);
      send_req(ACTION_SAMPLE, 0);
      send_req(ACTION_SAMPLE, 32767);
      send_req(ACTION_SAMPLE, -32768);
      send_req(ACTION_SAMPLE, 50);
      send_req(ACTION_SAMPLE, 200);
      send_req(ACTION_SAMPLE, -32768);
      send_req(ACTION_SAMPLE, 100);
      send_req(ACTION_SAMPLE, -51);
      wait_drain();
      write_csr(CSR_OUTLIER_THRESHOLD, 16'hFFFF);
      send_req(ACTION_SAMPLE, 32767);
      send_req(ACTION_SAMPLE, -32768);
      wait_drain();
      write_csr(CSR_OUTLIER_THRESHOLD, 16'h0000);
      send_req(ACTION_SAMPLE, 50);
      send_req(ACTION_SAMPLE, 32767);
      wait_drain();
      write_csr(CSR_WINDOW_LENGTH, 16'd1);
      send_req(ACTION_CLEAR, -1);
      send_req(ACTION_SAMPLE, -5);
      send_req(ACTION_SAMPLE, 7);
      wait_drain();
      write_csr(CSR_WINDOW_LENGTH, 16'd0);
      send_req(ACTION_SAMPLE, 3);
      send_req(ACTION_CLEAR, 0);
      wait_drain();
      write_csr(CSR_WINDOW_LENGTH, 16'd31);
      write_csr(CSR_OUTLIER_THRESHOLD, 16'd100);
      send_req(ACTION_SAMPLE, 1);
      send_req(ACTION_SAMPLE, 2);
      wait_drain();
      // upper bits of the length word are ignored
      write_csr(CSR_WINDOW_LENGTH, 16'hFFE3);
      send_req(ACTION_SAMPLE, 10);
      send_req(ACTION_SAMPLE, 20);
      send_req(ACTION_SAMPLE, 30);
      send_req(ACTION_SAMPLE, 40);

      for (int p = 0; p < 12; p++) begin
         wait_drain();
         case (p % 6)
            0: thr = 100;
            1: thr = 0;
            2: thr = 65535;
            3: thr = 1;
            4: thr = $urandom_range(300);
            default: thr = $urandom_range(65535);
         endcase
         len = (p == 11) ? $urandom_range(1, 16) : len_set[p];
         len_word = {CsrDataW{1'b0}};
         if ($urandom_range(1)) len_word = CsrDataW'($urandom_range(65535));
         len_word[CountW-1:0] = CountW'(len);
         if (p % 3 != 2) write_csr(CSR_WINDOW_LENGTH, len_word);
         write_csr(CSR_OUTLIER_THRESHOLD, CsrDataW'(thr));
         case (p % 4)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 50; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 50; end
            default: begin send_idle_pct = 35; recv_stall_pct = 35; end
         endcase
         if (p == 4) hold_armed = 1'b1;
         run_phase(125, int'($urandom_range(65535)) - 32768, thr);
      end

      wait_drain();
      repeat (40) @(posedge clock);
      $display("Run covered %0d requests (%0d clears) over %0d register writes;",
               sent_count, clear_count, setting_count);
      $display("%0d responses checked, %0d samples rejected as outliers.",
               checked_count, rejected_count);
      if (mismatch_count == 0 && pending_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
